[rtl/kliq_pkg.sv]
// Package for the k-th live item removal queue.
// Holds the sizing constants, command and status codes, and the sequencer state type.
// No dependencies; every other file in rtl/ refers to it by scoped names.
package kliq_pkg;

  // Store sizing. The slot count must be a power of two.
  localparam int CAPACITY = 1024;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int NODES    = CAPACITY - 1;
  localparam int CNT_W    = ADDR_W + 1;

  // Field widths of the item and result ports.
  localparam int CMD_W    = 2;
  localparam int VALUE_W  = 31;
  localparam int RANK_W   = 11;
  localparam int STATUS_W = 2;

  // The remaining rank must hold both a rank and a live count.
  localparam int K_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;

  // Tree walk constants. The one-hot half-size starts at half the store.
  localparam logic [ADDR_W-1:0] HALF_ROOT = ADDR_W'(CAPACITY / 2);
  localparam logic [ADDR_W-1:0] ROOT_MID  = ADDR_W'(CAPACITY / 2 - 1);
  localparam logic [ADDR_W-1:0] LAST_NODE = ADDR_W'(NODES - 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_APPEND = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND = 2'd0,
    STATUS_NONE  = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_SWEEP = 2'd0,
    ST_IDLE  = 2'd1,
    ST_DESC  = 2'd2,
    ST_FETCH = 2'd3
  } state_t;

endpackage

[rtl/kth_live_item_removal_queue.sv]
// Top level of the k-th live item removal queue.
// Holds the value store, the live-count tree memory and the walk sequencer.
// Depends on kliq_pkg.

// An item is taken when start is high and busy is low. A remove walks the live-count
// tree from the root, one level per cycle through the single read port of the count
// memory, then reads the value store once: it holds busy through the descent and the
// fetch, and its result is strobed on out_valid in the cycle in which busy falls. An
// append walks the same path, incrementing counts, and holds busy through the descent;
// an append to a full store is not walked and its result is strobed in the next cycle,
// as is the none result of a remove whose rank is zero or beyond the live count. A
// clear, and likewise reset, zeroes the count memory one node per cycle, holding busy
// until the last node is zeroed. Results are shown for exactly one cycle and cannot be
// held off; the block may take the next item while a result is shown.
module kth_live_item_removal_queue (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [kliq_pkg::CMD_W-1:0]      in_command,
  input  logic [kliq_pkg::VALUE_W-1:0]    in_item_value,
  input  logic [kliq_pkg::RANK_W-1:0]     in_rank,
  output logic                            out_valid,
  output logic [kliq_pkg::STATUS_W-1:0]   out_status,
  output logic [kliq_pkg::VALUE_W-1:0]    out_found_value
);

  // Sequencer and walk registers.
  kliq_pkg::state_t                 state_r, state_nxt;
  logic [kliq_pkg::ADDR_W-1:0]      b_r, b_nxt;
  logic [kliq_pkg::ADDR_W-1:0]      half_r, half_nxt;
  logic [kliq_pkg::K_W-1:0]         k_r, k_nxt;
  logic [kliq_pkg::ADDR_W-1:0]      pos_r, pos_nxt;
  logic                             op_append_r, op_append_nxt;
  logic [kliq_pkg::CNT_W-1:0]       next_slot_r, next_slot_nxt;
  logic [kliq_pkg::CNT_W-1:0]       live_total_r, live_total_nxt;
  logic [kliq_pkg::ADDR_W-1:0]      sweep_r, sweep_nxt;
  logic                             out_valid_r, out_valid_nxt;
  kliq_pkg::status_t                out_status_r, out_status_nxt;
  logic [kliq_pkg::VALUE_W-1:0]     out_value_r, out_value_nxt;

  // Memories and their ports.
  logic [kliq_pkg::CNT_W-1:0]       cnt_mem [kliq_pkg::NODES];
  logic [kliq_pkg::CNT_W-1:0]       cnt_rd_q;
  logic                             cnt_we;
  logic [kliq_pkg::ADDR_W-1:0]      cnt_wa;
  logic [kliq_pkg::CNT_W-1:0]       cnt_wd;
  logic [kliq_pkg::ADDR_W-1:0]      cnt_ra;

  logic [kliq_pkg::VALUE_W-1:0]     item_mem [kliq_pkg::CAPACITY];
  logic [kliq_pkg::VALUE_W-1:0]     item_rd_q;
  logic                             item_we;
  logic [kliq_pkg::ADDR_W-1:0]      item_wa;
  logic [kliq_pkg::ADDR_W-1:0]      item_ra;

  // Decoded item and walk conditions.
  kliq_pkg::cmd_t                   cmd;
  logic                             store_full;
  logic                             rank_ok;
  logic [kliq_pkg::ADDR_W-1:0]      mid;
  logic                             last_level;
  logic                             go_left;
  logic [kliq_pkg::K_W-1:0]         cnt_ext;

  assign cmd        = kliq_pkg::cmd_t'(in_command);
  assign store_full = (next_slot_r == kliq_pkg::CNT_W'(kliq_pkg::CAPACITY));
  assign rank_ok    = (in_rank != '0) &&
                      (kliq_pkg::K_W'(in_rank) <= kliq_pkg::K_W'(live_total_r));
  assign mid        = b_r | (half_r - kliq_pkg::ADDR_W'(1));
  assign last_level = half_r[0];
  assign cnt_ext    = kliq_pkg::K_W'(cnt_rd_q);

  // An append follows the path of its slot; a remove goes left while the rank fits.
  assign go_left = op_append_r ? ((pos_r & half_r) == '0) : (k_r <= cnt_ext);

  assign busy            = (state_r != kliq_pkg::ST_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_value = out_value_r;

  // Next state of the sequencer.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      kliq_pkg::ST_SWEEP: begin
        if (sweep_r == kliq_pkg::LAST_NODE) begin
          state_nxt = kliq_pkg::ST_IDLE;
        end
      end
      kliq_pkg::ST_IDLE: begin
        if (start) begin
          case (cmd)
            kliq_pkg::CMD_APPEND: begin
              if (!store_full) begin
                state_nxt = kliq_pkg::ST_DESC;
              end
            end
            kliq_pkg::CMD_REMOVE: begin
              if (rank_ok) begin
                state_nxt = kliq_pkg::ST_DESC;
              end
            end
            kliq_pkg::CMD_CLEAR: begin
              state_nxt = kliq_pkg::ST_SWEEP;
            end
            default: begin
              state_nxt = kliq_pkg::ST_IDLE;
            end
          endcase
        end
      end
      kliq_pkg::ST_DESC: begin
        if (last_level) begin
          state_nxt = op_append_r ? kliq_pkg::ST_IDLE : kliq_pkg::ST_FETCH;
        end
      end
      kliq_pkg::ST_FETCH: begin
        state_nxt = kliq_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = kliq_pkg::ST_IDLE;
      end
    endcase
  end

  // Walk datapath, memory controls and result register loads.
  always_comb begin
    b_nxt          = b_r;
    half_nxt       = half_r;
    k_nxt          = k_r;
    pos_nxt        = pos_r;
    op_append_nxt  = op_append_r;
    next_slot_nxt  = next_slot_r;
    live_total_nxt = live_total_r;
    sweep_nxt      = sweep_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    cnt_we         = 1'b0;
    cnt_wa         = mid;
    cnt_wd         = cnt_rd_q;
    cnt_ra         = kliq_pkg::ROOT_MID;
    item_we        = 1'b0;
    item_wa        = next_slot_r[kliq_pkg::ADDR_W-1:0];
    item_ra        = b_r;
    case (state_r)
      kliq_pkg::ST_SWEEP: begin
        cnt_we    = 1'b1;
        cnt_wa    = sweep_r;
        cnt_wd    = '0;
        sweep_nxt = sweep_r + kliq_pkg::ADDR_W'(1);
      end
      kliq_pkg::ST_IDLE: begin
        // The root count is read every idle cycle, so a walk starts right away.
        if (start) begin
          b_nxt    = '0;
          half_nxt = kliq_pkg::HALF_ROOT;
          case (cmd)
            kliq_pkg::CMD_APPEND: begin
              if (store_full) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = kliq_pkg::STATUS_FULL;
                out_value_nxt  = '0;
              end else begin
                item_we        = 1'b1;
                pos_nxt        = next_slot_r[kliq_pkg::ADDR_W-1:0];
                op_append_nxt  = 1'b1;
                next_slot_nxt  = next_slot_r + kliq_pkg::CNT_W'(1);
                live_total_nxt = live_total_r + kliq_pkg::CNT_W'(1);
              end
            end
            kliq_pkg::CMD_REMOVE: begin
              // A rank within the live count always lands on a live slot.
              if (rank_ok) begin
                k_nxt          = kliq_pkg::K_W'(in_rank);
                op_append_nxt  = 1'b0;
                live_total_nxt = live_total_r - kliq_pkg::CNT_W'(1);
              end else begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = kliq_pkg::STATUS_NONE;
                out_value_nxt  = '0;
              end
            end
            kliq_pkg::CMD_CLEAR: begin
              next_slot_nxt  = '0;
              live_total_nxt = '0;
              sweep_nxt      = '0;
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      kliq_pkg::ST_DESC: begin
        // One tree level per cycle: update this node and read the next one.
        if (go_left) begin
          cnt_we = 1'b1;
          cnt_wd = op_append_r ? (cnt_rd_q + kliq_pkg::CNT_W'(1))
                               : (cnt_rd_q - kliq_pkg::CNT_W'(1));
        end else begin
          b_nxt = b_r | half_r;
          if (!op_append_r) begin
            k_nxt = k_r - cnt_ext;
          end
        end
        half_nxt = half_r >> 1;
        if (!last_level) begin
          cnt_ra = b_nxt | (half_nxt - kliq_pkg::ADDR_W'(1));
        end
        item_ra = b_nxt;
      end
      kliq_pkg::ST_FETCH: begin
        out_valid_nxt  = 1'b1;
        out_status_nxt = kliq_pkg::STATUS_FOUND;
        out_value_nxt  = item_rd_q;
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= kliq_pkg::ST_SWEEP;
      sweep_r      <= '0;
      next_slot_r  <= '0;
      live_total_r <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      sweep_r      <= sweep_nxt;
      next_slot_r  <= next_slot_nxt;
      live_total_r <= live_total_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Walk and result payload registers.
  always_ff @(posedge clk) begin
    b_r          <= b_nxt;
    half_r       <= half_nxt;
    k_r          <= k_nxt;
    pos_r        <= pos_nxt;
    op_append_r  <= op_append_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  // Live-count tree memory, indexed by each node's split point.
  always_ff @(posedge clk) begin
    if (cnt_we) begin
      cnt_mem[cnt_wa] <= cnt_wd;
    end
    cnt_rd_q <= cnt_mem[cnt_ra];
  end

  // Value store, written by appends and read at the leaf a remove reaches.
  always_ff @(posedge clk) begin
    if (item_we) begin
      item_mem[item_wa] <= in_item_value;
    end
    item_rd_q <= item_mem[item_ra];
  end

endmodule

[rtl/kliq_checker.sv]
// Port-level checker for the k-th live item removal queue, with its bind.
// Watches the command and result ports over time.
// Depends on kliq_pkg and on kth_live_item_removal_queue.
module kliq_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            start,
  input logic                            busy,
  input logic [kliq_pkg::CMD_W-1:0]      in_command,
  input logic [kliq_pkg::RANK_W-1:0]     in_rank,
  input logic                            out_valid,
  input logic [kliq_pkg::STATUS_W-1:0]   out_status,
  input logic [kliq_pkg::VALUE_W-1:0]    out_found_value
);

  logic accept;

  assign accept = start && !busy;

  // The count memory is swept after reset, so the block is busy right after it.
  a_busy_after_reset: assert property (@(posedge clk)
    !rst_n |=> busy)
    else $error("block not busy after reset");

  // An accepted clear starts a sweep.
  a_clear_sweeps: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_command == kliq_pkg::CMD_CLEAR) |=> busy)
    else $error("clear did not start a sweep");

  // A remove with rank zero reports none in the next cycle.
  a_rank_zero_none: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_command == kliq_pkg::CMD_REMOVE) && (in_rank == '0)
    |=> out_valid && (out_status == kliq_pkg::STATUS_NONE))
    else $error("rank zero remove did not report none");

  // An append never causes a none result.
  a_append_no_none: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (in_command == kliq_pkg::CMD_APPEND)
    |=> !(out_valid && (out_status == kliq_pkg::STATUS_NONE)))
    else $error("append caused a none result");

  // Only a found item carries a value.
  a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != kliq_pkg::STATUS_FOUND) |-> (out_found_value == '0))
    else $error("nonzero value on a result without an item");

endmodule

bind kth_live_item_removal_queue kliq_checker u_kliq_checker (.*);

[verif/tb_top.sv]
`timescale 1ns / 1ps
// Testbench for the k-th live item removal queue: directed and random command items,
// with a scoreboard class that predicts each result and checks what the block strobes.
// Depends on kliq_pkg and the kth_live_item_removal_queue top level.
module tb_top;

  // The command code that the block ignores.
  localparam logic [kliq_pkg::CMD_W-1:0] CMD_UNUSED  = 2'd3;
  localparam int                         CYCLE_LIMIT = 500000;
  // Longest busy stretch of the block, a clear; used for the quiet time at the end.
  localparam int                         SETTLE_CYCLES = kliq_pkg::CAPACITY + 64;

  // Keeps its own copy of the store and the queue of predicted results.
  class removal_tracker;
    typedef struct {
      kliq_pkg::status_t                status;
      logic [kliq_pkg::VALUE_W-1:0]     value;
    } outcome_t;

    logic [kliq_pkg::VALUE_W-1:0] slot_value [kliq_pkg::CAPACITY];
    bit                           slot_live  [kliq_pkg::CAPACITY];
    int unsigned                  next_free;
    int unsigned                  live_total;
    outcome_t                     awaited [$];
    int                           errors;

    function new();
      foreach (slot_live[i]) slot_live[i] = 1'b0;
      next_free  = 0;
      live_total = 0;
      errors     = 0;
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    // Works out what one accepted item does to the store and what it returns.
    function void note_command(logic [kliq_pkg::CMD_W-1:0] cmd,
                               logic [kliq_pkg::VALUE_W-1:0] value,
                               logic [kliq_pkg::RANK_W-1:0] rank);
      outcome_t    res;
      int unsigned seen;
      res.status = kliq_pkg::STATUS_NONE;
      res.value  = '0;
      seen       = 0;
      case (cmd)
        kliq_pkg::CMD_APPEND: begin
          if (next_free >= kliq_pkg::CAPACITY) begin
            res.status = kliq_pkg::STATUS_FULL;
            awaited.push_back(res);
          end else begin
            slot_value[next_free] = value;
            slot_live[next_free]  = 1'b1;
            next_free++;
            live_total++;
          end
        end
        kliq_pkg::CMD_REMOVE: begin
          // Rank zero and ranks past the live count find nothing.
          if (rank != 0 && rank <= live_total) begin
            for (int slot = 0; slot < kliq_pkg::CAPACITY; slot++) begin
              if (slot_live[slot]) begin
                seen++;
                if (seen == rank) begin
                  res.status      = kliq_pkg::STATUS_FOUND;
                  res.value       = slot_value[slot];
                  slot_live[slot] = 1'b0;
                  live_total--;
                  break;
                end
              end
            end
          end
          awaited.push_back(res);
        end
        kliq_pkg::CMD_CLEAR: begin
          // Values stay in the store, but no slot is live any more.
          foreach (slot_live[i]) slot_live[i] = 1'b0;
          next_free  = 0;
          live_total = 0;
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      errors++;
    endtask

    // Compares one strobed result with the oldest prediction.
    task check_result(logic [kliq_pkg::STATUS_W-1:0] status,
                      logic [kliq_pkg::VALUE_W-1:0] value);
      outcome_t want;
      if (awaited.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d value %0h", status, value));
      end else begin
        want = awaited.pop_front();
        if (status !== want.status)
          report_mismatch($sformatf("status %0d, predicted %s", status, want.status.name()));
        if (value !== want.value)
          report_mismatch($sformatf("found_value %0h, predicted %0h", value, want.value));
      end
    endtask
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          start = 1'b0;
  logic                          busy;
  logic [kliq_pkg::CMD_W-1:0]    in_command = '0;
  logic [kliq_pkg::VALUE_W-1:0]  in_item_value = '0;
  logic [kliq_pkg::RANK_W-1:0]   in_rank = '0;
  logic                          out_valid;
  logic [kliq_pkg::STATUS_W-1:0] out_status;
  logic [kliq_pkg::VALUE_W-1:0]  out_found_value;

  removal_tracker tracker;
  int             idle_pct;
  int             cycle_count = 0;

  kth_live_item_removal_queue dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_command      (in_command),
    .in_item_value   (in_item_value),
    .in_rank         (in_rank),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_found_value (out_found_value)
  );

  always #5 clk = ~clk;

  // Results are strobed for one cycle and checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1) begin
      tracker.check_result(out_status, out_found_value);
    end
  end

  // Hard stop in case the block hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("kth_live_item_removal_queue verification failed");
      $finish;
    end
  end

  // Presents one item, idling first at random, and waits until the block takes it.
  task automatic send_item(logic [kliq_pkg::CMD_W-1:0] cmd,
                           logic [kliq_pkg::VALUE_W-1:0] value,
                           logic [kliq_pkg::RANK_W-1:0] rank);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_command    <= cmd;
    in_item_value <= value;
    in_rank       <= rank;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
    tracker.note_command(cmd, value, rank);
  endtask

  // Holds the sender back until every predicted result has been seen.
  task automatic wait_drained();
    start <= 1'b0;
    while (tracker.pending() != 0) @(posedge clk);
  endtask

  // Mostly appends and in-range removes, with some broken ranks, clears and unused codes.
  task automatic send_mixed_item();
    int unsigned                  pick;
    int unsigned                  shape;
    logic [kliq_pkg::CMD_W-1:0]   cmd;
    logic [kliq_pkg::VALUE_W-1:0] value;
    logic [kliq_pkg::RANK_W-1:0]  rank;
    pick  = $urandom_range(199);
    shape = $urandom_range(15);
    value = kliq_pkg::VALUE_W'($urandom);
    if (shape == 0) value = '0;
    else if (shape == 1) value = '1;
    rank = kliq_pkg::RANK_W'($urandom);
    if (pick < 2) begin
      cmd = kliq_pkg::CMD_CLEAR;
    end else if (pick < 6) begin
      cmd = CMD_UNUSED;
    end else if (pick < 110) begin
      cmd = kliq_pkg::CMD_APPEND;
    end else begin
      cmd = kliq_pkg::CMD_REMOVE;
      if (tracker.live_total != 0 && shape < 12) begin
        if (shape == 2) rank = kliq_pkg::RANK_W'(1);
        else if (shape == 3) rank = kliq_pkg::RANK_W'(tracker.live_total);
        else rank = kliq_pkg::RANK_W'($urandom_range(tracker.live_total, 1));
      end else begin
        case (shape % 4)
          0:       rank = '0;
          1:       rank = kliq_pkg::RANK_W'(tracker.live_total + 1);
          2:       rank = '1;
          default: rank = kliq_pkg::RANK_W'($urandom_range(2047, 0));
        endcase
      end
    end
    send_item(cmd, value, rank);
  endtask

  initial begin
    tracker  = new();
    idle_pct = 21;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed items: empty store, value extremes, rank edges, unused code, clear.
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd1);
    send_item(kliq_pkg::CMD_REMOVE, '1, 11'd0);
    send_item(kliq_pkg::CMD_APPEND, '0, '1);
    send_item(kliq_pkg::CMD_APPEND, '1, '0);
    send_item(kliq_pkg::CMD_APPEND, 31'h2AAA_AAAA, 11'h7FF);
    send_item(kliq_pkg::CMD_APPEND, 31'h5555_5555, 11'h2AA);
    send_item(CMD_UNUSED, '1, '1);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd0);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd5);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'h7FF);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd1024);
    send_item(kliq_pkg::CMD_REMOVE, '1, 11'd4);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd2);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd1);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd1);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd1);
    send_item(kliq_pkg::CMD_APPEND, 31'd123, 11'd0);
    send_item(kliq_pkg::CMD_CLEAR, '1, '1);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd1);
    send_item(kliq_pkg::CMD_APPEND, 31'd1, 11'd0);
    send_item(kliq_pkg::CMD_APPEND, 31'd2, 11'd0);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd2);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'd1);
    wait_drained();

    // Random items with light sender idling.
    repeat (80) send_mixed_item();
    wait_drained();

    // Random items with heavy sender idling.
    idle_pct = 83;
    repeat (60) send_mixed_item();
    wait_drained();

    // Back to back: fill every free slot, then work on a full store.
    idle_pct = 0;
    while (tracker.next_free < kliq_pkg::CAPACITY) begin
      send_item(kliq_pkg::CMD_APPEND, kliq_pkg::VALUE_W'($urandom),
                kliq_pkg::RANK_W'($urandom));
    end
    send_item(kliq_pkg::CMD_APPEND, '1, '0);
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'(tracker.live_total));
    send_item(kliq_pkg::CMD_REMOVE, '0, 11'(tracker.live_total + 1));
    repeat (30) send_mixed_item();
    wait_drained();

    // Allow for a clear still in progress and any stray result.
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (tracker.errors == 0 && tracker.pending() == 0) begin
      $display("kth_live_item_removal_queue verification clean");
    end else begin
      $display("kth_live_item_removal_queue verification failed");
    end
    $finish;
  end

endmodule

[kth_live_item_removal_queue.f]
rtl/kliq_pkg.sv
rtl/kth_live_item_removal_queue.sv
rtl/kliq_checker.sv
verif/tb_top.sv
